>>> design/obba_pkg.sv
`default_nettype none
package obba_pkg;
    localparam int COORD_W = 32;
    localparam int LEV_W   = 5;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 36;
    localparam int NVAL    = 6;
    localparam int STACK_D = 32;
    localparam int DEP_W   = 6;
    localparam int RES_MAX = 32;
    localparam int STAT_W  = 4;
    localparam int CNT_W   = 4;

    localparam logic [7:0] FULL_MASK = 8'hFF;

    localparam logic [STAT_W-1:0] ST_FULL  = 4'd0;
    localparam logic [STAT_W-1:0] ST_X     = 4'd1;
    localparam logic [STAT_W-1:0] ST_Y     = 4'd2;
    localparam logic [STAT_W-1:0] ST_Z     = 4'd3;
    localparam logic [STAT_W-1:0] ST_XY    = 4'd4;
    localparam logic [STAT_W-1:0] ST_YZ    = 4'd5;
    localparam logic [STAT_W-1:0] ST_XZ    = 4'd6;
    localparam logic [STAT_W-1:0] ST_XYZ   = 4'd7;
    localparam logic [STAT_W-1:0] ST_OTHER = 4'd8;
    localparam logic [STAT_W-1:0] ST_DUP   = 4'd9;

    typedef enum logic [1:0] {
        CL_LEAF,
        CL_FLUSH,
        CL_SKIP
    } t_cls;

    typedef struct packed {
        t_cls                           cls;
        logic [COORD_W-1:0]             x;
        logic [COORD_W-1:0]             y;
        logic [COORD_W-1:0]             z;
        logic [LEV_W-1:0]               lev;
        logic [NVAL-1:0][VAL_W-1:0]     v;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0]             x;
        logic [COORD_W-1:0]             y;
        logic [COORD_W-1:0]             z;
        logic [LEV_W-1:0]               lev;
        logic [NVAL-1:0][VAL_W-1:0]     v;
        logic [STAT_W-1:0]              status;
    } t_res;

    typedef struct packed {
        logic               idle;
        logic               pend;
        logic [DEP_W-1:0]   depth;
        logic               err_hold;
    } t_eng_stat;

    function automatic logic [STAT_W-1:0] pattern_code(input logic [7:0] m);
        logic [STAT_W-1:0] c;
        case (m)
            8'hFF:   c = ST_FULL;
            8'h55:   c = ST_X;
            8'h33:   c = ST_Y;
            8'h0F:   c = ST_Z;
            8'h11:   c = ST_XY;
            8'h03:   c = ST_YZ;
            8'h05:   c = ST_XZ;
            8'h01:   c = ST_XYZ;
            default: c = ST_OTHER;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

>>> design/obba_front.sv
`default_nettype none
// Input classification and a two-entry item queue toward the engine.
module obba_front #(
    parameter int MAX_LEVEL  = 31,
    parameter int COORD_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic                                   i_kind,
    input  wire logic [obba_pkg::COORD_W-1:0]           i_x,
    input  wire logic [obba_pkg::COORD_W-1:0]           i_y,
    input  wire logic [obba_pkg::COORD_W-1:0]           i_z,
    input  wire logic [obba_pkg::LEV_W-1:0]             i_lev,
    input  wire logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0] i_v,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output obba_pkg::t_item                             o_item
);
    obba_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    obba_pkg::t_item w_item;
    logic [obba_pkg::COORD_W-1:0] w_cmask;
    logic            w_push, w_pop;

    always_comb begin
        for (int i = 0; i < obba_pkg::COORD_W; i++) begin
            w_cmask[i] = (i < COORD_BITS);
        end
        w_item.x   = i_x & w_cmask;
        w_item.y   = i_y & w_cmask;
        w_item.z   = i_z & w_cmask;
        w_item.lev = i_lev;
        // sign extend from the low VALUE_BITS bits
        for (int k = 0; k < obba_pkg::NVAL; k++) begin
            for (int b = 0; b < obba_pkg::VAL_W; b++) begin
                w_item.v[k][b] = (b < VALUE_BITS) ? i_v[k][b] : i_v[k][VALUE_BITS-1];
            end
        end
        if (i_kind) begin
            w_item.cls = obba_pkg::CL_FLUSH;
        end else if (i_lev == '0 || int'(i_lev) > MAX_LEVEL || int'(i_lev) >= COORD_BITS) begin
            w_item.cls = obba_pkg::CL_SKIP;
        end else begin
            w_item.cls = obba_pkg::CL_LEAF;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end
endmodule
`default_nettype wire

>>> design/obba_div.sv
`default_nettype none
// Six-lane restoring divider, one quotient bit per cycle, divisor 1..8.
module obba_div (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_start,
    input  wire logic [obba_pkg::NVAL-1:0][obba_pkg::SUM_W-1:0] i_dvd,
    input  wire logic [obba_pkg::CNT_W-1:0]                     i_dvs,
    output logic                                                o_done,
    output logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0]      o_quo
);
    localparam int STEP_W = $clog2(obba_pkg::SUM_W + 1);

    logic                                               r_busy;
    logic                                               r_done;
    logic [STEP_W-1:0]                                  r_step;
    logic [obba_pkg::CNT_W-1:0]                         r_dvs;
    logic [obba_pkg::NVAL-1:0]                          r_neg;
    logic [obba_pkg::NVAL-1:0][obba_pkg::SUM_W-1:0]     r_q;
    logic [obba_pkg::NVAL-1:0][obba_pkg::CNT_W-1:0]     r_rem;
    logic [obba_pkg::SUM_W-1:0]                         w_qs [obba_pkg::NVAL];

    always_comb begin
        for (int k = 0; k < obba_pkg::NVAL; k++) begin
            w_qs[k]  = r_neg[k] ? (~r_q[k] + 1'b1) : r_q[k];
            o_quo[k] = w_qs[k][obba_pkg::VAL_W-1:0];
        end
    end
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        logic [obba_pkg::CNT_W:0] sh;
        logic                     ge;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(obba_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_dvs <= i_dvs;
            for (int k = 0; k < obba_pkg::NVAL; k++) begin
                r_neg[k] <= i_dvd[k][obba_pkg::SUM_W-1];
                r_q[k]   <= i_dvd[k][obba_pkg::SUM_W-1] ? (~i_dvd[k] + 1'b1) : i_dvd[k];
                r_rem[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < obba_pkg::NVAL; k++) begin
                sh = {r_rem[k], r_q[k][obba_pkg::SUM_W-1]};
                ge = (sh >= {1'b0, r_dvs});
                r_rem[k] <= ge ? obba_pkg::CNT_W'(sh - {1'b0, r_dvs}) : sh[obba_pkg::CNT_W-1:0];
                r_q[k]   <= {r_q[k][obba_pkg::SUM_W-2:0], ge};
            end
        end
    end
endmodule
`default_nettype wire

>>> design/obba_engine.sv
`default_nettype none
// Ancestor stack sequencer: pops, averages, creates entries, adds children.
module obba_engine #(
    parameter int COORD_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  obba_pkg::t_item         i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output obba_pkg::t_res          o_res,
    output logic                    o_last,
    output obba_pkg::t_eng_stat     o_stat
);
    localparam int  LEV_W = obba_pkg::LEV_W;
    localparam int  DEP_W = obba_pkg::DEP_W;
    localparam longint ND_RAW = -longint'(999 * 256);
    localparam longint ND_LO  = -(longint'(1) << (VALUE_BITS - 1));
    localparam logic [obba_pkg::VAL_W-1:0] NODATA =
        obba_pkg::VAL_W'((ND_RAW < ND_LO) ? ND_LO : ND_RAW);
    // all-water averages: vs carries the no-data mark, the rest are zero
    localparam logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0] NODATA_AVG =
        {{((obba_pkg::NVAL-2)*obba_pkg::VAL_W){1'b0}}, NODATA, {obba_pkg::VAL_W{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIVW, S_EMIT, S_PADD, S_CREATE, S_ADDLEAF, S_ERR, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_FLUSH, PH_DESC, PH_TRIM
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic   r_flush;
    logic   r_err_hold;
    logic [DEP_W-1:0] r_depth;
    logic [DEP_W-1:0] r_rcnt;

    // ancestor stack, read and written at one index per cycle
    logic [obba_pkg::COORD_W-1:0] r_ax [obba_pkg::STACK_D];
    logic [obba_pkg::COORD_W-1:0] r_ay [obba_pkg::STACK_D];
    logic [obba_pkg::COORD_W-1:0] r_az [obba_pkg::STACK_D];
    logic [7:0]                   r_seen [obba_pkg::STACK_D];
    logic [obba_pkg::CNT_W-1:0]   r_cnt [obba_pkg::STACK_D];
    logic [obba_pkg::NVAL-1:0][obba_pkg::SUM_W-1:0] r_sum [obba_pkg::STACK_D];

    // current leaf
    logic [obba_pkg::COORD_W-1:0] r_x, r_y, r_z;
    logic [LEV_W-1:0]             r_lev;
    logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0] r_v;

    // entry being popped
    logic [obba_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [LEV_W-1:0]             r_plev;
    logic [obba_pkg::STAT_W-1:0]  r_pstat;
    logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0] r_avg;

    // held result and output register
    obba_pkg::t_res r_pend;
    logic           r_pend_v;
    obba_pkg::t_res r_out;
    logic           r_out_v;
    logic           r_out_last;

    logic [LEV_W-1:0] w_idx;
    logic [LEV_W-1:0] w_top;
    logic [obba_pkg::COORD_W-1:0] w_tmask, w_cmask;
    logic w_mismatch;
    logic w_out_free, w_can_emit, w_emit;
    logic w_out_load;
    obba_pkg::t_res w_new;
    logic w_div_start, w_div_done;
    logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0] w_quo;
    logic [7:0] w_bit;
    logic [obba_pkg::COORD_W-1:0] w_bx, w_by, w_bz;
    logic [LEV_W-1:0] w_blev;
    logic [LEV_W-1:0] w_pos;
    logic [2:0] w_sel;

    function automatic logic [obba_pkg::COORD_W-1:0] anc_mask(input logic [LEV_W-1:0] t);
        logic [obba_pkg::COORD_W-1:0] m;
        for (int i = 0; i < obba_pkg::COORD_W; i++) begin
            m[i] = (i < COORD_BITS) && (i >= COORD_BITS - int'(t));
        end
        return m;
    endfunction

    assign w_top = LEV_W'(r_depth - 1'b1);

    always_comb begin
        case (r_state)
            S_PADD:    w_idx = r_plev - 1'b1;
            S_CREATE:  w_idx = r_depth[LEV_W-1:0];
            S_ADDLEAF: w_idx = r_lev - 1'b1;
            default:   w_idx = w_top;
        endcase
    end

    assign w_tmask    = anc_mask(w_top);
    assign w_cmask    = anc_mask(r_depth[LEV_W-1:0]);
    assign w_mismatch = ((r_x & w_tmask) != r_ax[w_idx]) || ((r_y & w_tmask) != r_ay[w_idx])
                     || ((r_z & w_tmask) != r_az[w_idx]);

    // child bit of the octant being added
    always_comb begin
        if (r_state == S_PADD) begin
            w_bx = r_px;
            w_by = r_py;
            w_bz = r_pz;
            w_blev = r_plev;
        end else begin
            w_bx = r_x;
            w_by = r_y;
            w_bz = r_z;
            w_blev = r_lev;
        end
        w_pos = LEV_W'(COORD_BITS - 1 - int'(w_blev));
        w_sel = {w_bz[w_pos], w_by[w_pos], w_bx[w_pos]};
        w_bit = 8'd1 << w_sel;
    end

    assign w_out_free = !r_out_v || i_ready;
    assign w_can_emit = !r_pend_v || w_out_free;
    assign w_emit     = (r_state == S_EMIT || r_state == S_ERR) && w_can_emit;
    // held result moves out when a newer one arrives or the item finishes
    assign w_out_load = r_pend_v && ((w_emit && r_rcnt < DEP_W'(obba_pkg::RES_MAX))
                                  || (r_state == S_FIN && w_out_free));

    always_comb begin
        if (r_state == S_ERR) begin
            w_new.v      = '0;
            w_new.status = obba_pkg::ST_DUP;
            if (r_phase == PH_DESC) begin
                // duplicate on the leaf itself
                w_new.x   = r_x;
                w_new.y   = r_y;
                w_new.z   = r_z;
                w_new.lev = r_lev;
            end else begin
                w_new.x   = r_px;
                w_new.y   = r_py;
                w_new.z   = r_pz;
                w_new.lev = r_plev;
            end
        end else begin
            w_new.x      = r_px;
            w_new.y      = r_py;
            w_new.z      = r_pz;
            w_new.lev    = r_plev;
            w_new.v      = r_avg;
            w_new.status = r_pstat;
        end
    end

    assign w_div_start = (r_state == S_CHECK) && (r_cnt[w_idx] != '0);

    obba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start && o_stat.idle == 1'b0 && r_depth != '0 && (
                   (r_phase == PH_FLUSH) ||
                   (r_phase == PH_DESC && (r_depth > DEP_W'(r_lev) || w_mismatch
                                           || r_seen[w_idx] == obba_pkg::FULL_MASK)) ||
                   (r_phase == PH_TRIM && r_seen[w_idx] == obba_pkg::FULL_MASK))),
        .i_dvd   (r_sum[w_idx]),
        .i_dvs   (r_cnt[w_idx]),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_out_last;
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.pend     = r_pend_v;
    assign o_stat.depth    = r_depth;
    assign o_stat.err_hold = r_err_hold;

    always_ff @(posedge i_clk) begin
        logic pop;
        logic avg_solid;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_FLUSH;
            r_flush    <= 1'b0;
            r_err_hold <= 1'b0;
            r_depth    <= '0;
            r_rcnt     <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_out_v <= w_out_load || (r_out_v && !i_ready);
            if (w_out_load) begin
                r_out      <= r_pend;
                r_out_last <= (r_state == S_FIN);
            end
            // new result: the held one moves to the output, not the last
            if (w_emit && r_rcnt < DEP_W'(obba_pkg::RES_MAX)) begin
                r_pend   <= w_new;
                r_pend_v <= 1'b1;
                r_rcnt   <= r_rcnt + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    r_rcnt <= '0;
                    if (i_valid) begin
                        r_x   <= i_item.x;
                        r_y   <= i_item.y;
                        r_z   <= i_item.z;
                        r_lev <= i_item.lev;
                        r_v   <= i_item.v;
                        case (i_item.cls)
                            obba_pkg::CL_FLUSH: begin
                                r_flush <= 1'b1;
                                r_phase <= PH_FLUSH;
                                r_state <= r_err_hold ? S_FIN : S_CHECK;
                            end
                            obba_pkg::CL_LEAF: begin
                                r_flush <= 1'b0;
                                r_phase <= PH_DESC;
                                r_state <= r_err_hold ? S_IDLE : S_CHECK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CHECK: begin
                    pop = 1'b0;
                    if (r_depth != '0) begin
                        case (r_phase)
                            PH_FLUSH: pop = 1'b1;
                            PH_DESC:  pop = (r_depth > DEP_W'(r_lev)) || w_mismatch
                                         || (r_seen[w_idx] == obba_pkg::FULL_MASK);
                            default:  pop = (r_seen[w_idx] == obba_pkg::FULL_MASK);
                        endcase
                    end
                    if (pop) begin
                        r_px    <= r_ax[w_idx];
                        r_py    <= r_ay[w_idx];
                        r_pz    <= r_az[w_idx];
                        r_plev  <= w_idx;
                        r_pstat <= obba_pkg::pattern_code(r_seen[w_idx]);
                        if (r_cnt[w_idx] == '0) begin
                            r_avg   <= NODATA_AVG;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIVW;
                        end
                    end else if (r_phase == PH_DESC) begin
                        r_state <= S_CREATE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_avg   <= w_quo;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_can_emit) begin
                        if (r_plev != '0) begin
                            r_state <= S_PADD;
                        end else begin
                            r_depth <= '0;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_PADD: begin
                    if ((r_seen[w_idx] & w_bit) != '0) begin
                        r_phase <= PH_TRIM;
                        r_state <= S_ERR;
                    end else begin
                        avg_solid = $signed(r_avg[1]) > 0;
                        r_seen[w_idx] <= r_seen[w_idx] | w_bit;
                        if (avg_solid) begin
                            r_cnt[w_idx] <= r_cnt[w_idx] + 1'b1;
                            for (int k = 0; k < obba_pkg::NVAL; k++) begin
                                r_sum[w_idx][k] <= r_sum[w_idx][k]
                                    + {{(obba_pkg::SUM_W-obba_pkg::VAL_W){r_avg[k][obba_pkg::VAL_W-1]}},
                                       r_avg[k]};
                            end
                        end
                        r_depth <= r_depth - 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_CREATE: begin
                    if (r_depth < DEP_W'(r_lev)) begin
                        r_ax[w_idx]   <= r_x & w_cmask;
                        r_ay[w_idx]   <= r_y & w_cmask;
                        r_az[w_idx]   <= r_z & w_cmask;
                        r_seen[w_idx] <= '0;
                        r_cnt[w_idx]  <= '0;
                        r_sum[w_idx]  <= '0;
                        r_depth       <= r_depth + 1'b1;
                    end else begin
                        r_state <= S_ADDLEAF;
                    end
                end
                S_ADDLEAF: begin
                    if ((r_seen[w_idx] & w_bit) != '0) begin
                        r_state <= S_ERR;
                    end else begin
                        r_seen[w_idx] <= r_seen[w_idx] | w_bit;
                        if ($signed(r_v[1]) > 0) begin
                            r_cnt[w_idx] <= r_cnt[w_idx] + 1'b1;
                            for (int k = 0; k < obba_pkg::NVAL; k++) begin
                                r_sum[w_idx][k] <= r_sum[w_idx][k]
                                    + {{(obba_pkg::SUM_W-obba_pkg::VAL_W){r_v[k][obba_pkg::VAL_W-1]}},
                                       r_v[k]};
                            end
                        end
                        r_phase <= PH_TRIM;
                        r_state <= S_CHECK;
                    end
                end
                S_ERR: begin
                    if (w_can_emit) begin
                        r_err_hold <= 1'b1;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_pend_v || w_out_free) begin
                        r_pend_v <= 1'b0;
                        if (r_flush) begin
                            r_depth    <= '0;
                            r_err_hold <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/octree_bottom_up_averager.sv
// Each leaf walks the ancestor stack in the engine; each ancestor popped passes through
// sequencing and, when it holds a solid child, the six-lane divider, one quotient bit
// a cycle over the 36-bit sums.
// One item is in the engine at a time, so a new item waits until the last one is done; a
// two-entry queue in front and a held result plus output register behind decouple stalls.
// Reset: i_rst_n synchronous active low; empties stack and queue, clears the error hold.
`default_nettype none
module octree_bottom_up_averager #(
    parameter int MAX_LEVEL  = 31,
    parameter int COORD_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] x_coord, [63:32] y_coord, [95:64] z_coord, [100:96] tree_level,
    // [132:101] vp_in, [164:133] vs_in, [196:165] density_in, [228:197] qp_in,
    // [260:229] qs_in, [292:261] surface_depth_in, [295:293] zero
    input  wire logic [295:0]   s_axis_tdata,
    // [0] kind: 0 leaf, 1 end of stream
    input  wire logic           s_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [100:96] out_level,
    // [132:101] vp_avg, [164:133] vs_avg, [196:165] density_avg, [228:197] qp_avg,
    // [260:229] qs_avg, [292:261] surface_depth_avg, [295:293] zero
    output logic [295:0]        m_axis_tdata,
    // [3:0] status
    output logic [3:0]          m_axis_tuser,
    output logic                m_axis_tlast
);
    localparam int VB = obba_pkg::VAL_W;

    logic [obba_pkg::NVAL-1:0][obba_pkg::VAL_W-1:0] w_in_v;
    logic            w_q_valid, w_q_ready;
    obba_pkg::t_item w_q_item;
    obba_pkg::t_res  w_res;
    obba_pkg::t_eng_stat w_stat;

    // unpack the six value fields; vp_in sits lowest
    always_comb begin
        for (int k = 0; k < obba_pkg::NVAL; k++) begin
            w_in_v[k] = s_axis_tdata[101 + k*VB +: VB];
        end
    end

    obba_front #(
        .MAX_LEVEL  (MAX_LEVEL),
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_x     (s_axis_tdata[31:0]),
        .i_y     (s_axis_tdata[63:32]),
        .i_z     (s_axis_tdata[95:64]),
        .i_lev   (s_axis_tdata[100:96]),
        .i_v     (w_in_v),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    obba_engine #(
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res),
        .o_last  (m_axis_tlast),
        .o_stat  (w_stat)
    );

    // result packing, same layout as the input item
    always_comb begin
        m_axis_tdata           = '0;
        m_axis_tdata[31:0]     = w_res.x;
        m_axis_tdata[63:32]    = w_res.y;
        m_axis_tdata[95:64]    = w_res.z;
        m_axis_tdata[100:96]   = w_res.lev;
        for (int k = 0; k < obba_pkg::NVAL; k++) begin
            m_axis_tdata[101 + k*VB +: VB] = w_res.v[k];
        end
        m_axis_tuser = w_res.status;
    end

    // stack never holds more than MAX_LEVEL entries
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_stat.depth) <= MAX_LEVEL)
        else $error("ancestor stack overflow");

    // an error result always closes its item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == obba_pkg::ST_DUP |-> m_axis_tlast)
        else $error("duplicate-child result not marked last");

    // engine back in idle has handed over every result of the item
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.idle |-> !w_stat.pend)
        else $error("result left held while idle");

    // error hold only clears on end of stream, which also empties the stack
    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_stat.err_hold) |-> w_stat.depth == '0)
        else $error("error hold cleared without reset of stack");
endmodule
`default_nettype wire

>>> bench/octree_bottom_up_averager_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module octree_bottom_up_averager_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;
    localparam logic KIND_LEAF  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic signed [31:0] WATER_VS = -32'sd255744; // -999 * 256

    typedef struct packed {
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  lev;
        logic [5:0][31:0] v;   // v[0] vp .. v[5] surface depth
    } t_octant;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  lev;
        logic [5:0][31:0] v;
        logic [3:0]  status;
        logic        last;
    } t_avg;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [295:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;

    octree_bottom_up_averager dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor state: one pending ancestor per level
    logic [31:0]        pa_x [32];
    logic [31:0]        pa_y [32];
    logic [31:0]        pa_z [32];
    logic [7:0]         pa_seen [32];
    logic [3:0]         pa_solid [32];
    logic signed [63:0] pa_sum [32][6];
    int                 pa_top;
    bit                 pa_err;

    t_avg expected_avgs[$];
    int   step_count;   // results produced by the current step
    int   err_count = 0;
    bit   hold_off = 1'b0;
    int   idle_cycles = 0;

    function automatic logic [31:0] level_mask(int lev);
        return 32'(~((64'd1 << (32 - lev)) - 64'd1));
    endfunction

    task automatic clear_stack();
        pa_top = -1;
        pa_err = 1'b0;
        for (int l = 0; l < 32; l++) begin
            pa_x[l] = '0; pa_y[l] = '0; pa_z[l] = '0;
            pa_seen[l] = '0; pa_solid[l] = '0;
            for (int k = 0; k < 6; k++) pa_sum[l][k] = '0;
        end
    endtask

    function automatic void push_avg(logic [31:0] x, y, z, int lev, logic signed [63:0] v[6],
                                     logic [3:0] st);
        t_avg r;
        if (step_count >= obba_pkg::RES_MAX) return;
        r.x = x; r.y = y; r.z = z; r.lev = lev[4:0];
        for (int k = 0; k < 6; k++) r.v[k] = v[k][31:0];
        r.status = st;
        r.last = 1'b0;
        expected_avgs.push_back(r);
        step_count++;
    endfunction

    function automatic void push_dup(logic [31:0] x, y, z, int lev);
        logic signed [63:0] zv[6];
        for (int k = 0; k < 6; k++) zv[k] = 0;
        push_avg(x, y, z, lev, zv, obba_pkg::ST_DUP);
        pa_err = 1'b1;
    endfunction

    // octant code from the coordinate bit just below the child's own level
    function automatic logic [7:0] octant_bit(logic [31:0] x, y, z, int lev);
        int p;
        p = 31 - lev;
        return 8'd1 << {z[p], y[p], x[p]};
    endfunction

    function automatic logic [3:0] mask_status(logic [7:0] m);
        case (m)
            8'hFF: return obba_pkg::ST_FULL;
            8'h55: return obba_pkg::ST_X;
            8'h33: return obba_pkg::ST_Y;
            8'h0F: return obba_pkg::ST_Z;
            8'h11: return obba_pkg::ST_XY;
            8'h03: return obba_pkg::ST_YZ;
            8'h05: return obba_pkg::ST_XZ;
            8'h01: return obba_pkg::ST_XYZ;
            default: return obba_pkg::ST_OTHER;
        endcase
    endfunction

    function automatic bit add_to_parent(logic [31:0] x, y, z, int lev,
                                         logic signed [63:0] v[6]);
        int p;
        logic [7:0] b;
        p = lev - 1;
        b = octant_bit(x, y, z, lev);
        if ((pa_seen[p] & b) != 0) return 1'b0;
        pa_seen[p] |= b;
        if (v[1] > 0) begin
            pa_solid[p]++;
            for (int k = 0; k < 6; k++) pa_sum[p][k] += v[k];
        end
        return 1'b1;
    endfunction

    // emits the deepest pending ancestor and folds it into its parent
    function automatic bit close_top();
        int l;
        logic signed [63:0] a[6];
        l = pa_top;
        for (int k = 0; k < 6; k++)
            a[k] = (pa_solid[l] == 0) ? 0 : pa_sum[l][k] / $signed({60'd0, pa_solid[l]});
        if (pa_solid[l] == 0) a[1] = WATER_VS;
        push_avg(pa_x[l], pa_y[l], pa_z[l], l, a, mask_status(pa_seen[l]));
        if (l > 0 && !add_to_parent(pa_x[l], pa_y[l], pa_z[l], l, a)) begin
            push_dup(pa_x[l], pa_y[l], pa_z[l], l);
            return 1'b0;
        end
        pa_top = l - 1;
        return 1'b1;
    endfunction

    task automatic predict_octant(t_octant it);
        int lev;
        bit ok;
        logic signed [63:0] v[6];
        step_count = 0;
        ok = 1'b1;
        lev = it.lev;
        if (it.kind == KIND_FLUSH) begin
            if (!pa_err)
                while (pa_top >= 0 && ok) ok = close_top();
            clear_stack();
        end else if (!pa_err && lev != 0) begin
            for (int k = 0; k < 6; k++) v[k] = $signed(it.v[k]);
            while (ok && pa_top >= lev) ok = close_top();
            while (ok && pa_top >= 0) begin
                logic [31:0] m;
                m = level_mask(pa_top);
                if ((it.x & m) != pa_x[pa_top] || (it.y & m) != pa_y[pa_top] ||
                    (it.z & m) != pa_z[pa_top] || pa_seen[pa_top] == obba_pkg::FULL_MASK)
                    ok = close_top();
                else
                    break;
            end
            if (ok) begin
                for (int l = pa_top + 1; l < lev; l++) begin
                    pa_x[l] = it.x & level_mask(l);
                    pa_y[l] = it.y & level_mask(l);
                    pa_z[l] = it.z & level_mask(l);
                    pa_seen[l] = '0; pa_solid[l] = '0;
                    for (int k = 0; k < 6; k++) pa_sum[l][k] = '0;
                    pa_top = l;
                end
                if (!add_to_parent(it.x, it.y, it.z, lev, v)) begin
                    push_dup(it.x, it.y, it.z, lev);
                end else begin
                    while (ok && pa_top >= 0 && pa_seen[pa_top] == obba_pkg::FULL_MASK)
                        ok = close_top();
                end
            end
        end
        if (step_count > 0) expected_avgs[$].last = 1'b1;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    // ---------------- result side
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_avg e;
            if (expected_avgs.size() == 0) begin
                report("unexpected item", m_axis_tdata[63:0], 0);
            end else begin
                e = expected_avgs.pop_front();
                if (m_axis_tdata[31:0] !== e.x)   report("x", m_axis_tdata[31:0], e.x);
                if (m_axis_tdata[63:32] !== e.y)  report("y", m_axis_tdata[63:32], e.y);
                if (m_axis_tdata[95:64] !== e.z)  report("z", m_axis_tdata[95:64], e.z);
                if (m_axis_tdata[100:96] !== e.lev)
                    report("level", m_axis_tdata[100:96], e.lev);
                for (int k = 0; k < 6; k++)
                    if (m_axis_tdata[101 + 32*k +: 32] !== e.v[k])
                        report($sformatf("value%0d", k), m_axis_tdata[101 + 32*k +: 32], e.v[k]);
                if (m_axis_tdata[295:293] !== 3'd0) report("pad", m_axis_tdata[295:293], 0);
                if (m_axis_tuser !== e.status) report("status", m_axis_tuser, e.status);
                if (m_axis_tlast !== e.last)   report("last", m_axis_tlast, e.last);
            end
        end
    end

    // receiver stalls; hold_off gives one long back-pressure stretch
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else begin
                gap = $urandom_range(0, 9);
                if (gap < 6) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat ((gap == 9) ? $urandom_range(20, 60) : $urandom_range(1, 3))
                        @(negedge i_clk);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL octree_bottom_up_averager");
            $finish;
        end
    end

    // ---------------- stimulus
    t_octant vectors[$];

    // drives at a falling edge, at times after a random idle gap, returns at the accepting rising edge
    task automatic send_octant(t_octant it);
        @(negedge i_clk);
        if ($urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4) + (($urandom_range(0, 9) == 0) ? 40 : 0))
                @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {3'b000, it.v[5], it.v[4], it.v[3], it.v[2], it.v[1], it.v[0],
                          it.lev, it.z, it.y, it.x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_octant(it);
    endtask

    function automatic t_octant make_leaf(logic [31:0] x, y, z, int lev, bit water);
        t_octant it;
        it.kind = KIND_LEAF;
        it.x = x; it.y = y; it.z = z; it.lev = lev[4:0];
        for (int k = 0; k < 6; k++) it.v[k] = $urandom;
        it.v[1] = water ? -$signed({1'b0, $urandom_range(0, 1000)})
                        : {1'b0, $urandom_range(1, 32'h7fff_ffff)};
        return it;
    endfunction

    function automatic t_octant flush_item();
        t_octant it;
        it = '0;
        it.kind = KIND_FLUSH;
        return it;
    endfunction

    // eight children of one parent in order, a random subset unless all8, optional duplicate
    task automatic add_family(logic [31:0] bx, by, bz, int lev, bit all8, bit dup);
        int p;
        p = 31 - lev;
        for (int c = 0; c < 8; c++) begin
            logic [31:0] x, y, z;
            if (!all8 && $urandom_range(0, 2) == 0) continue;
            x = bx | (c[0] << p); y = by | (c[1] << p); z = bz | (c[2] << p);
            vectors.push_back(make_leaf(x, y, z, lev, $urandom_range(0, 3) == 0));
            if (dup && c == 3) vectors.push_back(make_leaf(x, y, z, lev, 1'b0));
        end
    endtask

    initial begin
        t_octant it;
        clear_stack();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full family of level-1 leaves, extremes, all water
        for (int c = 0; c < 8; c++) begin
            it = make_leaf({1'b0, c[0], 30'd0}, {1'b0, c[1], 30'd0}, {1'b0, c[2], 30'd0},
                           1, 1'b0);
            it.v = {6{(c < 4) ? 32'h7fff_ffff : 32'h0000_0001}};
            vectors.push_back(it);
        end
        it = make_leaf('1, '1, '1, 31, 1'b0);
        it.v = {6{32'h8000_0000}};
        it.v[1] = 32'h7fff_ffff;
        vectors.push_back(it);
        vectors.push_back(make_leaf(32'h4000_0000, 0, 0, 2, 1'b1));  // all water
        vectors.push_back(make_leaf(0, 0, 0, 0, 1'b0));              // root ignored
        vectors.push_back(flush_item());
        vectors.push_back(make_leaf(0, 0, 0, 3, 1'b0));
        vectors.push_back(make_leaf(0, 0, 0, 3, 1'b0));              // duplicate child
        vectors.push_back(make_leaf(32'h2000_0000, 0, 0, 3, 1'b0));  // held error
        vectors.push_back(flush_item());
        foreach (vectors[i]) send_octant(vectors[i]);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        vectors.delete();

        // long receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int f = 0; f < 4; f++) begin
                    add_family(0, 0, 0, 2, 1'b1, 1'b0);
                    vectors.push_back(flush_item());
                end
                foreach (vectors[i]) send_octant(vectors[i]);
            end
        join
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        vectors.delete();

        // random trees with random depth, content and holes, plus stray leaves and duplicates
        while (vectors.size() < 110) begin
            int lev, sel;
            logic [31:0] bx, by, bz;
            lev = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 31) : $urandom_range(1, 5);
            sel = $urandom_range(0, 19);
            bx = $urandom & level_mask(lev - 1);
            by = $urandom & level_mask(lev - 1);
            bz = $urandom & level_mask(lev - 1);
            if (sel == 0) begin
                it = make_leaf($urandom, $urandom, $urandom, $urandom_range(0, 31),
                               $urandom_range(0, 1));
                vectors.push_back(it);
            end else begin
                add_family(bx, by, bz, lev, $urandom_range(0, 1), sel == 1);
                if (lev > 1 && $urandom_range(0, 1))
                    add_family(bx & level_mask(lev - 2), by & level_mask(lev - 2),
                               bz & level_mask(lev - 2), lev - 1, 1'b0, 1'b0);
            end
            if ($urandom_range(0, 3) == 0) vectors.push_back(flush_item());
        end
        vectors.push_back(flush_item());
        foreach (vectors[i]) send_octant(vectors[i]);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (expected_avgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_avgs.size() == 0) begin
            $display("PASS octree_bottom_up_averager");
        end else begin
            $display("FAIL octree_bottom_up_averager");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> octree_bottom_up_averager.f
design/obba_pkg.sv
design/obba_front.sv
design/obba_div.sv
design/obba_engine.sv
design/octree_bottom_up_averager.sv
bench/octree_bottom_up_averager_tb.sv
